/* rtl/core/isingm_pkg.sv */
// ----------------------------------------------------------------------------
// isingm_pkg
// Shared widths, register indexes and the result record of the Ising
// Metropolis spin update block.
// ----------------------------------------------------------------------------
`default_nettype none

package isingm_pkg;

    // default lattice sides
    localparam int SIDE_X_DEF = 64;
    localparam int SIDE_Y_DEF = 64;

    // input field widths
    localparam int SITE_IDX_W = 6;
    localparam int SITE_IDX_N = 64;
    localparam int RND_W      = 16;

    // threshold registers
    localparam int NUM_THR  = 5;
    localparam int THR_W    = 17;
    localparam int THR_REG_W = 2 * THR_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_M4 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P4 = 3'd4;

    // neighbour up-spin counts
    localparam int UPS_W = 3;
    localparam logic [UPS_W-1:0] UPS_0 = 3'd0;
    localparam logic [UPS_W-1:0] UPS_1 = 3'd1;
    localparam logic [UPS_W-1:0] UPS_2 = 3'd2;
    localparam logic [UPS_W-1:0] UPS_3 = 3'd3;
    localparam logic [UPS_W-1:0] UPS_4 = 3'd4;

    // result field widths
    localparam int CNT_W  = 32;
    localparam int MAG_W  = 14;
    localparam int UP_W   = 13;
    localparam int BOND_W = 15;

    // stream data widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    // result record, lowest field last so it packs from bit 0 upwards
    typedef struct packed {
        logic signed [BOND_W-1:0] bond_sum;
        logic [UP_W-1:0]          up_count;
        logic signed [MAG_W-1:0]  magnetization;
        logic [CNT_W-1:0]         accept_count;
        logic                     new_spin;
        logic                     accepted;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

`default_nettype wire

/* rtl/core/isingm_row_store.sv */
// ----------------------------------------------------------------------------
// isingm_row_store
// Spin lattice held as one row of spins per word. Two registered read ports,
// one write port, forwarding of a write that lands on a row read at the same
// edge, and a fill pass after reset that sets every spin up.
// ----------------------------------------------------------------------------
`default_nettype none

module isingm_row_store #(
    parameter int SIDE_X = isingm_pkg::SIDE_X_DEF,
    parameter int SIDE_Y = isingm_pkg::SIDE_Y_DEF,
    parameter int RW     = $clog2(SIDE_X)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [RW-1:0]     i_rd_addr_a,
    input  wire logic [RW-1:0]     i_rd_addr_b,
    input  wire logic              i_wr_en,
    input  wire logic [RW-1:0]     i_wr_addr,
    input  wire logic [SIDE_Y-1:0] i_wr_data,
    output logic [SIDE_Y-1:0]      o_rd_data_a,
    output logic [SIDE_Y-1:0]      o_rd_data_b,
    output logic                   o_busy
);

    localparam logic [RW-1:0] LAST_ROW = RW'(SIDE_X - 1);

    logic [SIDE_Y-1:0] mem [SIDE_X];

    logic [SIDE_Y-1:0] r_rd_a;
    logic [SIDE_Y-1:0] r_rd_b;
    logic [RW-1:0]     r_addr_a;
    logic [RW-1:0]     r_addr_b;
    logic              r_fwd_v;
    logic [RW-1:0]     r_fwd_addr;
    logic [SIDE_Y-1:0] r_fwd_data;
    logic              r_busy;
    logic [RW-1:0]     r_fill_addr;

    logic              w_we;
    logic [RW-1:0]     w_waddr;
    logic [SIDE_Y-1:0] w_wdata;

    // fill pass owns the write port until every row is set
    always_comb begin
        w_we    = r_busy ? 1'b1 : i_wr_en;
        w_waddr = r_busy ? r_fill_addr : i_wr_addr;
        w_wdata = r_busy ? '1 : i_wr_data;
    end

    // storage array, read first
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_a     <= mem[i_rd_addr_a];
        r_rd_b     <= mem[i_rd_addr_b];
        r_addr_a   <= i_rd_addr_a;
        r_addr_b   <= i_rd_addr_b;
        r_fwd_addr <= w_waddr;
        r_fwd_data <= w_wdata;
    end

    // fill sequencer and write-forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_fill_addr <= '0;
            r_fwd_v     <= 1'b0;
        end else begin
            r_fwd_v <= w_we;
            if (r_busy) begin
                if (r_fill_addr == LAST_ROW) begin
                    r_busy <= 1'b0;
                end
                r_fill_addr <= r_fill_addr + 1'b1;
            end
        end
    end

    // a row written at the edge of its read comes from the forward register
    always_comb begin
        o_rd_data_a = (r_fwd_v && r_fwd_addr == r_addr_a) ? r_fwd_data : r_rd_a;
        o_rd_data_b = (r_fwd_v && r_fwd_addr == r_addr_b) ? r_fwd_data : r_rd_b;
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* rtl/core/ising_metropolis_spin_update.sv */
// An item passes the neighbour capture and update stages (r_p1, r_p2); its
// result is then written into the two-entry output queue.
// No new item is taken while one is in neighbour capture or the queue is full;
// three lattice rows are read per item over the two read ports of the row store
// (neighbour rows, then the site row). Reset: a fill pass sets every spin up,
// s_axis_tready stays low meanwhile; configuration writes are taken during it.
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis single-spin update on a periodic lattice with table-driven
// acceptance and running magnetisation, up count, bond sum and accept count.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update #(
    parameter int SIDE_X = isingm_pkg::SIDE_X_DEF,
    parameter int SIDE_Y = isingm_pkg::SIDE_Y_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // site_row[5:0], site_col[11:6], random_value[27:12], clear_accepts[28]
    input  wire logic [isingm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // accepted[0], new_spin[1], accept_count[33:2], magnetization[47:34],
    // up_count[60:48], bond_sum[75:61]
    output logic [isingm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [isingm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [isingm_pkg::THR_REG_W-1:0]    i_cfg_data
);

    import isingm_pkg::*;

    localparam int RW     = $clog2(SIDE_X);
    localparam int CW     = $clog2(SIDE_Y);
    localparam int NSITES = SIDE_X * SIDE_Y;
    localparam logic [RW-1:0]     ROW_LAST = RW'(SIDE_X - 1);
    localparam logic [CW-1:0]     COL_LAST = CW'(SIDE_Y - 1);
    localparam logic [MAG_W-1:0]  MAG_RST  = MAG_W'(NSITES);
    localparam logic [UP_W-1:0]   UP_RST   = UP_W'(NSITES);
    localparam logic [BOND_W-1:0] BOND_RST = BOND_W'(2 * NSITES);

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    logic [THR_REG_W-1:0] r_thr [NUM_THR];

    logic              r_p1;
    logic              r_p2;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [RND_W-1:0]  r_rnd;
    logic              r_clr;
    logic              r_nb_a;
    logic              r_nb_b;

    logic [CNT_W-1:0]         r_acc_cnt;
    logic signed [MAG_W-1:0]  r_mag;
    logic [UP_W-1:0]          r_up;
    logic signed [BOND_W-1:0] r_bond;

    t_result     r_ofifo [2];
    logic        r_owr;
    logic        r_ord;
    logic [1:0]  r_ocnt;

    logic [RW-1:0] w_row_tab [SITE_IDX_N];
    logic [CW-1:0] w_col_tab [SITE_IDX_N];

    logic          s_fire;
    logic          m_fire;
    logic [RW-1:0] w_in_row;
    logic [CW-1:0] w_in_col;
    logic [RW-1:0] w_in_rm;
    logic [RW-1:0] w_in_rp;
    logic [CW-1:0] w_cm;
    logic [CW-1:0] w_cp;

    logic [RW-1:0]     w_rd_addr_a;
    logic [SIDE_Y-1:0] w_rd_a;
    logic [SIDE_Y-1:0] w_rd_b;
    logic [SIDE_Y-1:0] w_wr_row;
    logic              w_busy;

    logic                     w_s;
    logic [UPS_W-1:0]         w_ups;
    logic [THR_REG_W-1:0]     w_reg;
    logic [THR_W-1:0]         w_th;
    logic                     w_acc;
    logic [CNT_W-1:0]         w_cnt_base;
    logic [CNT_W-1:0]         n_acc_cnt;
    logic signed [MAG_W-1:0]  n_mag;
    logic [UP_W-1:0]          n_up;
    logic signed [BOND_W-1:0] w_bd;
    logic signed [BOND_W-1:0] n_bond;
    t_result                  w_res;

    // ------------------------------------------------------------------
    // site index reduction tables, worked out at elaboration
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < SITE_IDX_N; gi++) begin : g_idx_tab
        assign w_row_tab[gi] = RW'(gi % SIDE_X);
        assign w_col_tab[gi] = CW'(gi % SIDE_Y);
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THR; i++) begin
                r_thr[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THR_M4: r_thr[0] <= i_cfg_data;
                CFG_THR_M2: r_thr[1] <= i_cfg_data;
                CFG_THR_0:  r_thr[2] <= i_cfg_data;
                CFG_THR_P2: r_thr[3] <= i_cfg_data;
                CFG_THR_P4: r_thr[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input side: site decode and neighbour row addresses
    // ------------------------------------------------------------------
    always_comb begin
        w_in_row = w_row_tab[s_axis_tdata[SITE_IDX_W-1:0]];
        w_in_col = w_col_tab[s_axis_tdata[2*SITE_IDX_W-1:SITE_IDX_W]];
        w_in_rm  = (w_in_row == '0) ? ROW_LAST : w_in_row - 1'b1;
        w_in_rp  = (w_in_row == ROW_LAST) ? '0 : w_in_row + 1'b1;
        w_cm     = (r_col == '0) ? COL_LAST : r_col - 1'b1;
        w_cp     = (r_col == COL_LAST) ? '0 : r_col + 1'b1;
    end

    // room for the result is reserved at accept time
    assign s_axis_tready = !w_busy && !r_p1 &&
                           ((r_ocnt == 2'd0) || (r_ocnt == 2'd1 && !r_p2));
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // neighbour rows on accept, site row while the item is in neighbour capture
    assign w_rd_addr_a = r_p1 ? r_row : w_in_rm;

    isingm_row_store #(
        .SIDE_X (SIDE_X),
        .SIDE_Y (SIDE_Y),
        .RW     (RW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_in_rp),
        .i_wr_en     (r_p2 && w_acc),
        .i_wr_addr   (r_row),
        .i_wr_data   (w_wr_row),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b),
        .o_busy      (w_busy)
    );

    // item pipeline: accept, neighbour capture, update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= s_fire;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_row <= w_in_row;
            r_col <= w_in_col;
            r_rnd <= s_axis_tdata[2*SITE_IDX_W+RND_W-1:2*SITE_IDX_W];
            r_clr <= s_axis_tdata[2*SITE_IDX_W+RND_W];
        end
        if (r_p1) begin
            r_nb_a <= w_rd_a[r_col];
            r_nb_b <= w_rd_b[r_col];
        end
    end

    // ------------------------------------------------------------------
    // acceptance decision on the site row
    // ------------------------------------------------------------------
    always_comb begin
        w_s   = w_rd_a[r_col];
        w_ups = UPS_W'(r_nb_a) + UPS_W'(r_nb_b) + UPS_W'(w_rd_a[w_cm])
              + UPS_W'(w_rd_a[w_cp]);
        case (w_ups)
            UPS_0:   w_reg = r_thr[0];
            UPS_1:   w_reg = r_thr[1];
            UPS_2:   w_reg = r_thr[2];
            UPS_3:   w_reg = r_thr[3];
            UPS_4:   w_reg = r_thr[4];
            default: w_reg = '0;
        endcase
        w_th  = w_s ? w_reg[THR_W-1:0] : w_reg[THR_REG_W-1:THR_W];
        w_acc = {1'b0, r_rnd} < w_th;

        w_wr_row        = w_rd_a;
        w_wr_row[r_col] = ~w_s;
    end

    // ------------------------------------------------------------------
    // running totals
    // ------------------------------------------------------------------
    always_comb begin
        w_cnt_base = r_clr ? '0 : r_acc_cnt;
        n_acc_cnt  = (w_acc && w_cnt_base != '1) ? w_cnt_base + 1'b1 : w_cnt_base;

        // bond change of a flip is s * (8 - 4 * ups)
        w_bd = BOND_W'({w_ups, 2'b00}) - BOND_W'(8);

        n_mag  = r_mag;
        n_up   = r_up;
        n_bond = r_bond;
        if (w_acc) begin
            n_mag  = w_s ? r_mag - MAG_W'(2) : r_mag + MAG_W'(2);
            n_up   = w_s ? r_up - 1'b1 : r_up + 1'b1;
            n_bond = w_s ? r_bond - w_bd : r_bond + w_bd;
        end

        w_res.accepted      = w_acc;
        w_res.new_spin      = w_s ^ w_acc;
        w_res.accept_count  = n_acc_cnt;
        w_res.magnetization = n_mag;
        w_res.up_count      = n_up;
        w_res.bond_sum      = n_bond;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt <= '0;
            r_mag     <= MAG_RST;
            r_up      <= UP_RST;
            r_bond    <= BOND_RST;
        end else if (r_p2) begin
            r_acc_cnt <= n_acc_cnt;
            r_mag     <= n_mag;
            r_up      <= n_up;
            r_bond    <= n_bond;
        end
    end

    // ------------------------------------------------------------------
    // two-entry output queue
    // ------------------------------------------------------------------
    assign m_axis_tvalid = (r_ocnt != 2'd0);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_ofifo[r_ord]};

    always_ff @(posedge i_clk) begin
        if (r_p2) begin
            r_ofifo[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (r_p2) begin
                r_owr <= ~r_owr;
            end
            if (m_fire) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + {1'b0, r_p2} - {1'b0, m_fire};
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stage_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_p1 && r_p2))
        else $error("capture and update stages overlap");

    a_fire_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_p1)
        else $error("accepted item did not reach neighbour capture");

    a_p1_p2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |=> r_p2)
        else $error("neighbour capture not followed by update");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("output queue overflow");

    a_fill_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("input taken during lattice fill");

endmodule

`default_nettype wire
